// ----- rtl/core/segd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segd_pkg
// Shared types and constants of the signed Exp-Golomb decoder.
// ----------------------------------------------------------------------------
package segd_pkg;

    // Code format limits
    localparam int MAX_CODE_BITS = 63;
    localparam int BITS_PER_BYTE = 8;

    // Datapath widths
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int ACC_W    = 63;
    localparam int ZRUN_W   = 8;
    localparam int BBL_W    = ZRUN_W + 1;
    localparam int CWLEN_W  = ZRUN_W + 2;
    localparam int BIDX_W   = $clog2(BITS_PER_BYTE);
    localparam int SHIFT_W  = $clog2(VALUE_W);

    // Item queue between front and back (depth must be a power of two)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item classes
    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_HEADER = 1'b1
    } t_kind;

    // Classified stream item
    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  data_byte;
        logic               last;
    } t_item;

    // One result item
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      is_value;
        logic                      code_error;
        logic                      last_in_run;
    } t_result;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_BITS = 2'd0,
        ST_END  = 2'd1,
        ST_MARK = 2'd2
    } t_back_state;

endpackage
`default_nettype wire

// ----- rtl/core/segd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segd_in_if
// Byte stream channel: valid/ready with data byte and stream flags.
// ----------------------------------------------------------------------------
interface segd_in_if;
    import segd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              is_header;
    logic              is_last;

    modport source (output valid, output data_byte, output is_header, output is_last,
                    input ready);
    modport sink   (input valid, input data_byte, input is_header, input is_last,
                    output ready);
endinterface
`default_nettype wire

// ----- rtl/core/segd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segd_out_if
// Result channel: valid/ready with decoded value and result flags.
// ----------------------------------------------------------------------------
interface segd_out_if;
    import segd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      is_value;
    logic                      code_error;
    logic                      last_in_run;

    modport source (output valid, output value, output is_value, output code_error,
                    output last_in_run, input ready);
    modport sink   (input valid, input value, input is_value, input code_error,
                    input last_in_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/segd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segd_front
// Accepts stream bytes, classifies them as header or data and queues them
// for the back end.
// ----------------------------------------------------------------------------
module segd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    segd_in_if.sink             i_in,
    output segd_pkg::t_item     o_head,
    output logic                o_head_valid,
    input  wire logic           i_pop
);
    import segd_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;
    t_item             w_item;

    // Classification of the incoming byte
    always_comb begin
        w_item.kind      = i_in.is_header ? KIND_HEADER : KIND_DATA;
        w_item.data_byte = i_in.data_byte;
        w_item.last      = i_in.is_last;
    end

    assign i_in.ready   = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push       = i_in.valid && i_in.ready;
    assign o_head_valid = (r_count != '0);
    assign w_pop        = i_pop && o_head_valid;
    assign o_head       = r_mem[r_rd_ptr];

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    // Queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/segd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// segd_back
// Decodes codewords from the queued byte's code bits, one per cycle unless a
// finished codeword waits on the output register, which delivers results.
// ----------------------------------------------------------------------------
module segd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire segd_pkg::t_item i_head,
    input  wire logic           i_head_valid,
    output logic                o_pop,
    segd_out_if.source          o_out
);
    import segd_pkg::*;

    // Sequencer
    t_back_state r_state, n_state;
    logic [BIDX_W-1:0] r_bit_idx, n_bit_idx;

    // Codeword state
    logic [BYTE_W-1:0] r_order_k, n_order_k;
    logic [ZRUN_W-1:0] r_zero_run, n_zero_run;
    logic              r_reading, n_reading;
    logic [BBL_W-1:0]  r_bbl, n_bbl;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic              r_ovf, n_ovf;

    // Held result, waiting to learn whether it is the last of its byte
    logic               r_pend_valid, n_pend_valid;
    logic [VALUE_W-1:0] r_pend_n, n_pend_n;
    logic               r_pend_err, n_pend_err;

    // Output register
    logic    r_out_valid;
    t_result r_out;

    // Bit step results
    logic               w_bit;
    logic [CWLEN_W-1:0] w_cwlen;
    logic [BBL_W-1:0]   w_bbl_start;
    logic [ZRUN_W-1:0]  b_zero_run;
    logic               b_reading;
    logic [BBL_W-1:0]   b_bbl;
    logic [ACC_W-1:0]   b_acc;
    logic               b_ovf;
    logic               b_fin;
    logic [VALUE_W-1:0] b_n;

    logic               w_can_push;
    logic               w_is_data;
    logic               w_bit_stall;
    logic [VALUE_W-1:0] w_half;
    logic [VALUE_W-1:0] w_pend_value;
    logic               w_push;
    t_result            w_push_data;

    assign w_can_push = !r_out_valid || o_out.ready;
    assign w_is_data  = i_head_valid && (i_head.kind == KIND_DATA);
    assign w_bit      = i_head.data_byte[~r_bit_idx];

    // Codeword length and body length once the terminating one is seen
    assign w_cwlen     = {1'b0, r_zero_run, 1'b0} + {2'b00, r_order_k} + CWLEN_W'(1);
    assign w_bbl_start = {1'b0, r_zero_run} + {1'b0, r_order_k};

    // One code bit applied to the codeword state
    always_comb begin
        b_zero_run = r_zero_run;
        b_reading  = r_reading;
        b_bbl      = r_bbl;
        b_acc      = r_acc;
        b_ovf      = r_ovf;
        b_fin      = 1'b0;
        if (!r_reading) begin
            if (!w_bit) begin
                if (r_zero_run != '1) begin
                    b_zero_run = r_zero_run + 1'b1;
                end
            end else begin
                b_ovf     = (w_cwlen > CWLEN_W'(MAX_CODE_BITS));
                b_acc     = ACC_W'(1);
                b_bbl     = w_bbl_start;
                b_reading = 1'b1;
                b_fin     = (w_bbl_start == '0);
            end
        end else begin
            if (!r_ovf) begin
                b_acc = {r_acc[ACC_W-2:0], w_bit};
            end
            b_bbl = r_bbl - 1'b1;
            b_fin = (r_bbl == BBL_W'(1));
        end
    end

    // n = x - 2^k; only meaningful when the codeword did not overflow
    assign b_n = {1'b0, b_acc} - (VALUE_W'(1) << r_order_k[SHIFT_W-1:0]);

    // A finished codeword needs the held result pushed out first
    assign w_bit_stall = w_is_data && b_fin && r_pend_valid && !w_can_push;

    // Signed mapping of the held n: odd -> (n+1)/2, even -> -(n/2)
    always_comb begin
        if (r_pend_n[0]) begin
            w_half = (r_pend_n + VALUE_W'(1)) >> 1;
        end else begin
            w_half = ~(r_pend_n >> 1) + VALUE_W'(1);
        end
        w_pend_value = r_pend_err ? '0 : w_half;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_BITS: begin
                if (i_head_valid) begin
                    if (i_head.kind == KIND_HEADER) begin
                        n_state = ST_END;
                    end else if (!w_bit_stall && (r_bit_idx == BIDX_W'(BITS_PER_BYTE - 1))) begin
                        n_state = ST_END;
                    end
                end
            end
            ST_END: begin
                if (r_pend_valid) begin
                    if (w_can_push) begin
                        n_state = i_head.last ? ST_MARK : ST_BITS;
                    end
                end else if (!i_head.last || w_can_push) begin
                    n_state = ST_BITS;
                end
            end
            ST_MARK: begin
                if (w_can_push) begin
                    n_state = ST_BITS;
                end
            end
            default: n_state = ST_BITS;
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        n_bit_idx    = r_bit_idx;
        n_order_k    = r_order_k;
        n_zero_run   = r_zero_run;
        n_reading    = r_reading;
        n_bbl        = r_bbl;
        n_acc        = r_acc;
        n_ovf        = r_ovf;
        n_pend_valid = r_pend_valid;
        n_pend_n     = r_pend_n;
        n_pend_err   = r_pend_err;
        o_pop        = 1'b0;
        w_push       = 1'b0;
        w_push_data  = '0;
        unique case (r_state)
            ST_BITS: begin
                if (i_head_valid && (i_head.kind == KIND_HEADER)) begin
                    // Header: new order, fresh codeword
                    n_order_k  = i_head.data_byte;
                    n_zero_run = '0;
                    n_reading  = 1'b0;
                    n_bbl      = '0;
                    n_acc      = '0;
                    n_ovf      = 1'b0;
                end else if (w_is_data && !w_bit_stall) begin
                    n_bit_idx  = r_bit_idx + 1'b1;
                    n_zero_run = b_zero_run;
                    n_reading  = b_reading;
                    n_bbl      = b_bbl;
                    n_acc      = b_acc;
                    n_ovf      = b_ovf;
                    if (b_fin) begin
                        if (r_pend_valid) begin
                            w_push                  = 1'b1;
                            w_push_data.value       = w_pend_value;
                            w_push_data.is_value    = !r_pend_err;
                            w_push_data.code_error  = r_pend_err;
                            w_push_data.last_in_run = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_n     = b_n;
                        n_pend_err   = b_ovf;
                        n_zero_run   = '0;
                        n_reading    = 1'b0;
                        n_bbl        = '0;
                        n_acc        = '0;
                        n_ovf        = 1'b0;
                    end
                end
            end
            ST_END: begin
                if (r_pend_valid) begin
                    if (w_can_push) begin
                        w_push                  = 1'b1;
                        w_push_data.value       = w_pend_value;
                        w_push_data.is_value    = !r_pend_err;
                        w_push_data.code_error  = r_pend_err;
                        w_push_data.last_in_run = !i_head.last;
                        n_pend_valid            = 1'b0;
                        o_pop                   = !i_head.last;
                    end
                end else if (!i_head.last) begin
                    o_pop = 1'b1;
                end else if (w_can_push) begin
                    // End marker straight away
                    w_push                  = 1'b1;
                    w_push_data.last_in_run = 1'b1;
                    o_pop                   = 1'b1;
                    n_zero_run              = '0;
                    n_reading               = 1'b0;
                    n_bbl                   = '0;
                    n_acc                   = '0;
                    n_ovf                   = 1'b0;
                end
            end
            ST_MARK: begin
                if (w_can_push) begin
                    w_push                  = 1'b1;
                    w_push_data.last_in_run = 1'b1;
                    o_pop                   = 1'b1;
                    n_zero_run              = '0;
                    n_reading               = 1'b0;
                    n_bbl                   = '0;
                    n_acc                   = '0;
                    n_ovf                   = 1'b0;
                end
            end
            default: begin
                n_bit_idx = '0;
            end
        endcase
    end

    // Control and codeword state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_BITS;
            r_bit_idx    <= '0;
            r_order_k    <= '0;
            r_zero_run   <= '0;
            r_reading    <= 1'b0;
            r_bbl        <= '0;
            r_acc        <= '0;
            r_ovf        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bit_idx    <= n_bit_idx;
            r_order_k    <= n_order_k;
            r_zero_run   <= n_zero_run;
            r_reading    <= n_reading;
            r_bbl        <= n_bbl;
            r_acc        <= n_acc;
            r_ovf        <= n_ovf;
            r_pend_valid <= n_pend_valid;
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pend_n   <= n_pend_n;
        r_pend_err <= n_pend_err;
        if (w_push) begin
            r_out <= w_push_data;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out.value;
    assign o_out.is_value    = r_out.is_value;
    assign o_out.code_error  = r_out.code_error;
    assign o_out.last_in_run = r_out.last_in_run;

endmodule
`default_nettype wire

// ----- rtl/core/signed_exp_golomb_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// signed_exp_golomb_decoder_unit
// Signed Exp-Golomb decoder of order k over a byte stream.
//
//   Channel  Dir  Payload                                      Transfer
//   i_in     in   data_byte[8], is_header, is_last             valid & ready
//   o_out    out  value[64] signed, is_value, code_error,      valid & ready
//                 last_in_run
//
// A data byte is walked code bit by code bit through the bit sequencer,
// then the end state releases the last result of the byte; a last byte
// that also held a result sends the end marker from a separate state.
// Header bytes pass through the sequencer state and the end state. A
// two-entry queue lets the front accept bytes while the back works, and
// the output register lets the back go on while a result waits. Reset
// (i_rst_n low, synchronous) clears the order k and all codeword state.
// A stall on o_out holds the back only when it has a result to hand over.
// ----------------------------------------------------------------------------
module signed_exp_golomb_decoder_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    segd_in_if.sink    i_in,
    segd_out_if.source o_out
);
    import segd_pkg::*;

    t_item w_head;
    logic  w_head_valid;
    logic  w_pop;

    // Input side and item queue
    segd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_head       (w_head),
        .o_head_valid (w_head_valid),
        .i_pop        (w_pop)
    );

    // Bit sequencer and result output
    segd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_head_valid (w_head_valid),
        .o_pop        (w_pop),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire
